FILE: rtl/core/pst_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions of the Pascal subset tokenizer.
// Depends on nothing; every other file of the block imports it.
package pst_pkg;

  localparam int LINE_WIDTH_DEF   = 16;
  localparam int COLUMN_WIDTH_DEF = 16;
  localparam int LENGTH_WIDTH_DEF = 8;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int KIND_WIDTH = 5;
  localparam int BYTE_WIDTH = 8;
  localparam int NUM_KW     = 11;

  typedef enum logic [KIND_WIDTH-1:0] {
    TK_END     = 5'd0,
    TK_ERROR   = 5'd1,
    TK_IDENT   = 5'd2,
    TK_NUMBER  = 5'd3,
    TK_PROGRAM = 5'd4,
    TK_BEGIN   = 5'd5,
    TK_KW_END  = 5'd6,
    TK_VAR     = 5'd7,
    TK_INTEGER = 5'd8,
    TK_REAL    = 5'd9,
    TK_IF      = 5'd10,
    TK_THEN    = 5'd11,
    TK_ELSE    = 5'd12,
    TK_WHILE   = 5'd13,
    TK_DO      = 5'd14,
    TK_LT      = 5'd15,
    TK_LE      = 5'd16,
    TK_NE      = 5'd17,
    TK_GT      = 5'd18,
    TK_GE      = 5'd19,
    TK_EQ      = 5'd20,
    TK_SEMI    = 5'd21,
    TK_DOT     = 5'd22,
    TK_COMMA   = 5'd23,
    TK_COLON   = 5'd24,
    TK_ASSIGN  = 5'd25,
    TK_LPAREN  = 5'd26,
    TK_RPAREN  = 5'd27,
    TK_PLUS    = 5'd28,
    TK_MINUS   = 5'd29,
    TK_STAR    = 5'd30,
    TK_SLASH   = 5'd31
  } token_kind_e;

  // Scanner state: which kind of lexeme is still open.
  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_IDENT   = 6'b000010,
    M_NUMBER  = 6'b000100,
    M_LESS    = 6'b001000,
    M_GREATER = 6'b010000,
    M_COLON   = 6'b100000
  } scan_mode_e;

  // Which of the two token slots of a queue entry hold a token.
  typedef struct packed {
    logic b;
    logic a;
  } tok_valid_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Keyword text is right-aligned: the last character sits in the low byte.
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'("program"), 64'("begin"), 64'("end"), 64'("var"), 64'("integer"),
    64'("real"), 64'("if"), 64'("then"), 64'("else"), 64'("while"), 64'("do")
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd7, 3'd5, 3'd3, 3'd3, 3'd7, 3'd4, 3'd2, 3'd4, 3'd4, 3'd5, 3'd2
  };

  function automatic logic [BYTE_WIDTH-1:0] kw_char(int unsigned k, logic [2:0] p);
    int idx;
    idx = int'(KW_LEN[k]) - 1 - int'(p);
    if (idx >= 0) begin
      return KW_TEXT[k][8*idx +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic is_letter(logic [BYTE_WIDTH-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [BYTE_WIDTH-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [BYTE_WIDTH-1:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Single-byte symbols; anything unknown is an error token.
  function automatic token_kind_e sym_kind(logic [BYTE_WIDTH-1:0] c);
    token_kind_e k;
    unique case (c)
      8'h3D:   k = TK_EQ;
      8'h3B:   k = TK_SEMI;
      8'h2E:   k = TK_DOT;
      8'h2C:   k = TK_COMMA;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_STAR;
      8'h2F:   k = TK_SLASH;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/core/pst_front.sv
`timescale 1ns / 1ps
// Scanner front end: takes one source byte per cycle while the queue has room,
// tracks position and the open lexeme, and pushes up to two finished tokens per byte. Uses pst_pkg.
module pst_front #(
  parameter int LINE_WIDTH   = pst_pkg::LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = pst_pkg::COLUMN_WIDTH_DEF,
  parameter int LENGTH_WIDTH = pst_pkg::LENGTH_WIDTH_DEF,
  parameter int TDATA_W      = 56
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               text_byte_i,
  input  logic                     is_end_i,
  input  pst_pkg::q_stat_t         q_stat_i,
  output logic                     push_o,
  output pst_pkg::tok_valid_t      push_vld_o,
  output logic [2*TDATA_W-1:0]     push_data_o
);
  import pst_pkg::*;

  localparam int LW = LINE_WIDTH;
  localparam int CW = COLUMN_WIDTH;
  localparam int NW = LENGTH_WIDTH;

  scan_mode_e         mode_q, mode_d;
  logic [LW-1:0]      cur_line_q, cur_line_d, st_line_q, st_line_d;
  logic [CW-1:0]      cur_col_q, cur_col_d, st_col_q, st_col_d;
  logic [NW-1:0]      len_q, len_d, len_inc;
  logic [7:0]         first_q, first_d;
  logic [NUM_KW-1:0]  cand_q, cand_d;
  logic               fin_q, fin_d;

  logic               accept;
  logic [7:0]         c;
  logic               let_c, dig_c, sp_c;
  logic               pending, cont, pair_hit;
  token_kind_e        flush_kind, pair_kind;
  logic [LW-1:0]      adv_line;
  logic [CW-1:0]      adv_col;
  logic [TDATA_W-1:0] tok_a, tok_b;
  tok_valid_t         vld;

  function automatic logic [TDATA_W-1:0] pack_tok(token_kind_e k, logic [LW-1:0] l,
                                                  logic [CW-1:0] col, logic [7:0] f,
                                                  logic [NW-1:0] n);
    return TDATA_W'({n, f, col, l, k});
  endfunction

  function automatic logic [NUM_KW-1:0] narrow(logic [NUM_KW-1:0] cand,
                                               logic [NW-1:0] p, logic [7:0] ch);
    logic [NUM_KW-1:0] r;
    r = cand;
    for (int unsigned k = 0; k < NUM_KW; k++) begin
      if (!(p < NW'(KW_LEN[k]) && kw_char(k, p[2:0]) == ch)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  assign c          = text_byte_i;
  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign let_c   = is_letter(c);
  assign dig_c   = is_digit(c);
  assign sp_c    = is_space(c);
  assign pending = (mode_q != M_IDLE);
  assign len_inc = (len_q == '1) ? len_q : len_q + NW'(1);

  assign cont = ((mode_q == M_IDENT) && (let_c || dig_c)) ||
                ((mode_q == M_NUMBER) && (dig_c || c == 8'h2E));

  // Position after this byte, saturating at the counter maximum.
  always_comb begin
    adv_line = cur_line_q;
    adv_col  = cur_col_q;
    if (c == 8'h0A) begin
      if (cur_line_q != '1) adv_line = cur_line_q + LW'(1);
      adv_col = CW'(1);
    end else if (cur_col_q != '1) begin
      adv_col = cur_col_q + CW'(1);
    end
  end

  always_comb begin
    flush_kind = TK_ERROR;
    unique case (mode_q)
      M_IDENT: begin
        flush_kind = TK_IDENT;
        for (int unsigned k = 0; k < NUM_KW; k++) begin
          if (cand_q[k] && len_q == NW'(KW_LEN[k])) begin
            flush_kind = token_kind_e'(KIND_WIDTH'(int'(TK_PROGRAM) + int'(k)));
          end
        end
      end
      M_NUMBER:  flush_kind = TK_NUMBER;
      M_LESS:    flush_kind = TK_LT;
      M_GREATER: flush_kind = TK_GT;
      M_COLON:   flush_kind = TK_COLON;
      default:   flush_kind = TK_ERROR;
    endcase
  end

  always_comb begin
    pair_hit  = 1'b1;
    pair_kind = TK_LE;
    if (mode_q == M_LESS && c == 8'h3D) begin
      pair_kind = TK_LE;
    end else if (mode_q == M_LESS && c == 8'h3E) begin
      pair_kind = TK_NE;
    end else if (mode_q == M_GREATER && c == 8'h3D) begin
      pair_kind = TK_GE;
    end else if (mode_q == M_COLON && c == 8'h3D) begin
      pair_kind = TK_ASSIGN;
    end else begin
      pair_hit = 1'b0;
    end
  end

  always_comb begin
    mode_d     = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    st_line_d  = st_line_q;
    st_col_d   = st_col_q;
    len_d      = len_q;
    first_d    = first_q;
    cand_d     = cand_q;
    fin_d      = fin_q;
    vld        = '0;
    tok_a      = pack_tok(flush_kind, st_line_q, st_col_q, first_q, len_q);
    tok_b      = pack_tok(TK_END, cur_line_q, cur_col_q, 8'h00, '0);

    if (is_end_i) begin
      vld.a  = !fin_q && pending;
      vld.b  = 1'b1;
      mode_d = M_IDLE;
      fin_d  = 1'b1;
    end else if (!fin_q) begin
      cur_line_d = adv_line;
      cur_col_d  = adv_col;
      if (cont) begin
        cand_d = narrow(cand_q, len_q, c);
        len_d  = len_inc;
      end else if (pair_hit) begin
        vld.b  = 1'b1;
        tok_b  = pack_tok(pair_kind, st_line_q, st_col_q, first_q, len_inc);
        len_d  = len_inc;
        mode_d = M_IDLE;
      end else begin
        // The open lexeme ends here; this byte then starts from idle.
        vld.a  = pending;
        mode_d = M_IDLE;
        if (sp_c) begin
          mode_d = M_IDLE;
        end else if (let_c || dig_c || c == 8'h3C || c == 8'h3E || c == 8'h3A) begin
          if (let_c) begin
            mode_d = M_IDENT;
          end else if (dig_c) begin
            mode_d = M_NUMBER;
          end else if (c == 8'h3C) begin
            mode_d = M_LESS;
          end else if (c == 8'h3E) begin
            mode_d = M_GREATER;
          end else begin
            mode_d = M_COLON;
          end
          st_line_d = cur_line_q;
          st_col_d  = cur_col_q;
          first_d   = c;
          len_d     = NW'(1);
          cand_d    = narrow('1, '0, c);
        end else begin
          vld.b = 1'b1;
          tok_b = pack_tok(sym_kind(c), cur_line_q, cur_col_q, c, NW'(1));
        end
      end
    end
  end

  assign push_o      = accept && (vld.a || vld.b);
  assign push_vld_o  = vld;
  assign push_data_o = {tok_b, tok_a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_IDLE;
      cur_line_q <= LW'(1);
      cur_col_q  <= CW'(1);
      st_line_q  <= LW'(1);
      st_col_q   <= CW'(1);
      len_q      <= '0;
      first_q    <= '0;
      cand_q     <= '1;
      fin_q      <= 1'b0;
    end else if (accept) begin
      mode_q     <= mode_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      st_line_q  <= st_line_d;
      st_col_q   <= st_col_d;
      len_q      <= len_d;
      first_q    <= first_d;
      cand_q     <= cand_d;
      fin_q      <= fin_d;
    end
  end

endmodule

FILE: rtl/core/pst_queue.sv
`timescale 1ns / 1ps
// Short queue of token pairs between the scanner and the output side.
// Uses pst_pkg for the status struct.
module pst_queue #(
  parameter int DEPTH = pst_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = 114
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              pop_i,
  output logic [WIDTH-1:0]  rdata_o,
  output pst_pkg::q_stat_t  stat_o
);
  import pst_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNTW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNTW'(1);
      2'b01:   cnt_d = cnt_q - CNTW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/pst_back.sv
`timescale 1ns / 1ps
// Output side: sends the one or two tokens of the queue head as single words
// and marks the last token of each source byte. Uses pst_pkg.
module pst_back #(
  parameter int TDATA_W = 56
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pst_pkg::q_stat_t     q_stat_i,
  input  logic [2*TDATA_W+1:0] head_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [TDATA_W-1:0]   m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);
  import pst_pkg::*;

  tok_valid_t         vld;
  logic [TDATA_W-1:0] tok_a, tok_b;
  logic               sel_q, sel_d;
  logic               cur_b, fire;

  assign {vld, tok_b, tok_a} = head_i;

  // The second slot goes out once the first has been taken, or alone.
  assign cur_b           = sel_q || !vld.a;
  assign m_axis_tvalid_o = !q_stat_i.empty;
  assign m_axis_tdata_o  = cur_b ? tok_b : tok_a;
  assign m_axis_tlast_o  = cur_b || !vld.b;
  assign fire            = m_axis_tvalid_o && m_axis_tready_i;
  assign pop_o           = fire && m_axis_tlast_o;

  always_comb begin
    sel_d = sel_q;
    if (fire) begin
      sel_d = !m_axis_tlast_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

FILE: rtl/core/pascal_subset_tokenizer.sv
`timescale 1ns / 1ps
// Pascal subset tokenizer: one source byte per word in, one token per word out.
// A byte is taken in every cycle while the token queue (QUEUE_DEPTH entries,
// one entry per byte that yields tokens) has room; whitespace that closes no
// lexeme and bytes inside an identifier or number yield nothing. A byte
// yields at most two tokens (an open lexeme closed by an operator or symbol,
// or a flush followed by the end token); the output sends one token per
// cycle while the sink is ready. A token can be taken in the cycle after the
// byte that closes it. Identifiers are matched against the keywords as their
// bytes arrive. After an end marker, further text is dropped until reset,
// and each further end marker yields another end token.
module pascal_subset_tokenizer #(
  parameter int LINE_WIDTH   = pst_pkg::LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = pst_pkg::COLUMN_WIDTH_DEF,
  parameter int LENGTH_WIDTH = pst_pkg::LENGTH_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = pst_pkg::QUEUE_DEPTH_DEF,
  localparam int FIELDS_W    = pst_pkg::KIND_WIDTH + LINE_WIDTH + COLUMN_WIDTH
                               + pst_pkg::BYTE_WIDTH + LENGTH_WIDTH,
  localparam int TDATA_W     = ((FIELDS_W + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // text_byte
  input  logic [0:0]         s_axis_tuser_i,   // is_end
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // token_kind, token_line, token_column, first_byte, token_length, zero fill
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic               m_axis_tlast_o    // last_of_run
);
  import pst_pkg::*;

  localparam int ENTRY_W = 2 * TDATA_W + 2;

  q_stat_t              q_stat;
  logic                 push, pop;
  tok_valid_t           push_vld;
  logic [2*TDATA_W-1:0] push_data;
  logic [ENTRY_W-1:0]   head;

  pst_front #(
    .LINE_WIDTH  (LINE_WIDTH),
    .COLUMN_WIDTH(COLUMN_WIDTH),
    .LENGTH_WIDTH(LENGTH_WIDTH),
    .TDATA_W     (TDATA_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .text_byte_i(s_axis_tdata_i),
    .is_end_i   (s_axis_tuser_i[0]),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_vld_o (push_vld),
    .push_data_o(push_data)
  );

  pst_queue #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({push_vld, push_data}),
    .pop_i  (pop),
    .rdata_o(head),
    .stat_o (q_stat)
  );

  pst_back #(
    .TDATA_W(TDATA_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .head_i         (head),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

FILE: rtl/core/pst_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the tokenizer, bound to the top level.
// Uses pst_pkg for token kinds and default widths.
module pst_checker #(
  parameter int LINE_WIDTH   = pst_pkg::LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = pst_pkg::COLUMN_WIDTH_DEF,
  parameter int LENGTH_WIDTH = pst_pkg::LENGTH_WIDTH_DEF,
  parameter int TDATA_W      = 56
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic [0:0]         s_axis_tuser_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o,
  input logic               m_axis_tlast_o
);
  import pst_pkg::*;

  localparam int LINE_LO  = KIND_WIDTH;
  localparam int COL_LO   = LINE_LO + LINE_WIDTH;
  localparam int FIRST_LO = COL_LO + COLUMN_WIDTH;
  localparam int LEN_LO   = FIRST_LO + BYTE_WIDTH;

  logic [KIND_WIDTH-1:0]   kind;
  logic [LINE_WIDTH-1:0]   line;
  logic [COLUMN_WIDTH-1:0] col;
  logic [BYTE_WIDTH-1:0]   first;
  logic [LENGTH_WIDTH-1:0] len;
  logic                    is_end_tok;

  assign kind       = m_axis_tdata_o[KIND_WIDTH-1:0];
  assign line       = m_axis_tdata_o[LINE_LO +: LINE_WIDTH];
  assign col        = m_axis_tdata_o[COL_LO +: COLUMN_WIDTH];
  assign first      = m_axis_tdata_o[FIRST_LO +: BYTE_WIDTH];
  assign len        = m_axis_tdata_o[LEN_LO +: LENGTH_WIDTH];
  assign is_end_tok = (kind == TK_END);

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // The second token of a byte is already waiting when the first is taken.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("second token of a byte missing");

  // The end token closes its byte and carries no lexeme.
  a_end_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && is_end_tok |-> m_axis_tlast_o && first == '0 && len == '0)
    else $error("malformed end token");

  // Positions count from one, and every other token has a lexeme.
  a_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> line != '0 && col != '0 && (is_end_tok || len != '0))
    else $error("token with zero position or empty lexeme");

  // An end marker taken on an empty output gives a word on the next cycle.
  a_end_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0] && !m_axis_tvalid_o
      |=> m_axis_tvalid_o)
    else $error("end marker produced no token");

endmodule

bind pascal_subset_tokenizer pst_checker #(
  .LINE_WIDTH  (LINE_WIDTH),
  .COLUMN_WIDTH(COLUMN_WIDTH),
  .LENGTH_WIDTH(LENGTH_WIDTH),
  .TDATA_W     (TDATA_W)
) u_pst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

FILE: sim/pascal_subset_tokenizer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Pascal subset tokenizer: source bytes in, tokens out,
// compared against a token scoreboard that tracks the scanner state on its own.
// Depends on pst_pkg and pascal_subset_tokenizer.

localparam int TOKEN_BITS = 56;

typedef struct {
  pst_pkg::token_kind_e kind;
  logic [15:0]          line;
  logic [15:0]          column;
  logic [7:0]           first;
  logic [7:0]           length;
  logic                 last;
} token_t;

function automatic string kw_word(int k);
  case (k)
    0:       return "program";
    1:       return "begin";
    2:       return "end";
    3:       return "var";
    4:       return "integer";
    5:       return "real";
    6:       return "if";
    7:       return "then";
    8:       return "else";
    9:       return "while";
    default: return "do";
  endcase
endfunction

class token_scoreboard;
  pst_pkg::scan_mode_e mode;
  logic [15:0] cur_line;
  logic [15:0] cur_col;
  logic [15:0] start_line;
  logic [15:0] start_col;
  logic [7:0]  lex_len;
  logic [7:0]  lex_first;
  logic [10:0] cand;
  bit          done;
  string       words[11];
  token_t      pending_q[$];
  int          mismatches;

  function new();
    mode       = pst_pkg::M_IDLE;
    cur_line   = 16'd1;
    cur_col    = 16'd1;
    start_line = 16'd1;
    start_col  = 16'd1;
    lex_len    = 8'd0;
    lex_first  = 8'd0;
    cand       = '1;
    done       = 0;
    mismatches = 0;
    for (int k = 0; k < 11; k++) words[k] = kw_word(k);
  endfunction

  function bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void push(pst_pkg::token_kind_e kind, logic [15:0] line, logic [15:0] column,
                     logic [7:0] first, logic [7:0] length);
    token_t t;
    t.kind   = kind;
    t.line   = line;
    t.column = column;
    t.first  = first;
    t.length = length;
    t.last   = 1'b0;
    pending_q.push_back(t);
  endfunction

  function void advance(logic [7:0] c);
    if (c == 8'h0A) begin
      if (cur_line != 16'hFFFF) cur_line++;
      cur_col = 16'd1;
    end else if (cur_col != 16'hFFFF) begin
      cur_col++;
    end
  endfunction

  // Keyword candidates drop out as soon as the byte at this position differs.
  function void extend(logic [7:0] c);
    int p;
    p = lex_len;
    for (int k = 0; k < 11; k++) begin
      if (cand[k] && (p >= words[k].len() || words[k][p] != c)) cand[k] = 1'b0;
    end
    if (lex_len != 8'hFF) lex_len++;
  endfunction

  function void open_lexeme(logic [7:0] c, pst_pkg::scan_mode_e m);
    mode       = m;
    start_line = cur_line;
    start_col  = cur_col;
    lex_first  = c;
    lex_len    = 8'd0;
    cand       = '1;
    extend(c);
  endfunction

  function void flush();
    pst_pkg::token_kind_e k;
    case (mode)
      pst_pkg::M_IDENT: begin
        k = pst_pkg::TK_IDENT;
        for (int kk = 0; kk < 11; kk++) begin
          if (cand[kk] && words[kk].len() == lex_len)
            k = pst_pkg::token_kind_e'(int'(pst_pkg::TK_PROGRAM) + kk);
        end
      end
      pst_pkg::M_NUMBER:  k = pst_pkg::TK_NUMBER;
      pst_pkg::M_LESS:    k = pst_pkg::TK_LT;
      pst_pkg::M_GREATER: k = pst_pkg::TK_GT;
      pst_pkg::M_COLON:   k = pst_pkg::TK_COLON;
      default:            return;
    endcase
    push(k, start_line, start_col, lex_first, lex_len);
    mode = pst_pkg::M_IDLE;
  endfunction

  function void take_byte(logic [7:0] c);
    pst_pkg::token_kind_e k;
    if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
      // Whitespace only moves the position.
    end else if (is_alpha(c)) begin
      open_lexeme(c, pst_pkg::M_IDENT);
    end else if (is_num(c)) begin
      open_lexeme(c, pst_pkg::M_NUMBER);
    end else if (c == "<") begin
      open_lexeme(c, pst_pkg::M_LESS);
    end else if (c == ">") begin
      open_lexeme(c, pst_pkg::M_GREATER);
    end else if (c == ":") begin
      open_lexeme(c, pst_pkg::M_COLON);
    end else begin
      case (c)
        "=":     k = pst_pkg::TK_EQ;
        ";":     k = pst_pkg::TK_SEMI;
        ".":     k = pst_pkg::TK_DOT;
        ",":     k = pst_pkg::TK_COMMA;
        "(":     k = pst_pkg::TK_LPAREN;
        ")":     k = pst_pkg::TK_RPAREN;
        "+":     k = pst_pkg::TK_PLUS;
        "-":     k = pst_pkg::TK_MINUS;
        "*":     k = pst_pkg::TK_STAR;
        "/":     k = pst_pkg::TK_SLASH;
        default: k = pst_pkg::TK_ERROR;
      endcase
      push(k, cur_line, cur_col, c, 8'd1);
    end
    advance(c);
  endfunction

  // Called for every accepted input word; queues the tokens it must produce.
  function void note_byte(logic [7:0] c, logic is_end);
    int                   prev_count;
    bit                   paired;
    pst_pkg::token_kind_e pk;
    prev_count = pending_q.size();
    paired     = 1'b1;
    pk         = pst_pkg::TK_ERROR;
    if (is_end) begin
      if (!done) flush();
      push(pst_pkg::TK_END, cur_line, cur_col, 8'd0, 8'd0);
      done = 1;
    end else if (!done) begin
      case (mode)
        pst_pkg::M_IDENT: begin
          if (is_alpha(c) || is_num(c)) begin
            extend(c);
            advance(c);
          end else begin
            flush();
            take_byte(c);
          end
        end
        pst_pkg::M_NUMBER: begin
          if (is_num(c) || c == ".") begin
            extend(c);
            advance(c);
          end else begin
            flush();
            take_byte(c);
          end
        end
        pst_pkg::M_LESS, pst_pkg::M_GREATER, pst_pkg::M_COLON: begin
          if (mode == pst_pkg::M_LESS && c == "=") pk = pst_pkg::TK_LE;
          else if (mode == pst_pkg::M_LESS && c == ">") pk = pst_pkg::TK_NE;
          else if (mode == pst_pkg::M_GREATER && c == "=") pk = pst_pkg::TK_GE;
          else if (mode == pst_pkg::M_COLON && c == "=") pk = pst_pkg::TK_ASSIGN;
          else paired = 1'b0;
          if (paired) begin
            if (lex_len != 8'hFF) lex_len++;
            advance(c);
            mode = pst_pkg::M_IDLE;
            push(pk, start_line, start_col, lex_first, lex_len);
          end else begin
            flush();
            take_byte(c);
          end
        end
        default: begin
          mode = pst_pkg::M_IDLE;
          take_byte(c);
        end
      endcase
    end
    if (pending_q.size() > prev_count) pending_q[pending_q.size()-1].last = 1'b1;
  endfunction

  function void check_token(logic [TOKEN_BITS-1:0] data, logic last);
    token_t exp;
    bit     bad;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected token: kind %0d line %0d col %0d first %02h len %0d last %0b",
                 data[4:0], data[20:5], data[36:21], data[44:37], data[52:45], last);
      return;
    end
    exp = pending_q.pop_front();
    bad = (data[4:0] !== exp.kind) || (data[20:5] !== exp.line) ||
          (data[36:21] !== exp.column) || (data[44:37] !== exp.first) ||
          (data[52:45] !== exp.length) || (data[55:53] !== 3'b000) || (last !== exp.last);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("token mismatch: expected kind %0d line %0d col %0d first %02h len %0d last %0b",
                 exp.kind, exp.line, exp.column, exp.first, exp.length, exp.last);
        $display("                actual   kind %0d line %0d col %0d first %02h len %0d last %0b",
                 data[4:0], data[20:5], data[36:21], data[44:37], data[52:45], last);
      end
    end
  endfunction
endclass

module pascal_subset_tokenizer_tb;
  import pst_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 150;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i  = 8'h00;  // text_byte
  logic [0:0]            s_axis_tuser_i  = 1'b0;   // is_end
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // token_kind, token_line, token_column, first_byte, token_length, zero fill
  logic [TOKEN_BITS-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;          // last_of_run

  token_scoreboard sb = new();
  int src_idle    = 0;
  int sink_stall  = 0;
  int bytes_sent  = 0;
  int quiet_count = 0;

  pascal_subset_tokenizer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic send_word(input logic [7:0] b, input logic is_end);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= is_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b, is_end);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    return (r < 52) ? rand_letter() : 8'(8'h30 + r - 52);
  endfunction

  function automatic string op_text(int k);
    case (k)
      0:       return "<";
      1:       return "<=";
      2:       return "<>";
      3:       return ">";
      4:       return ">=";
      5:       return ":";
      6:       return ":=";
      7:       return "=";
      8:       return ";";
      9:       return ".";
      10:      return ",";
      11:      return "(";
      12:      return ")";
      13:      return "+";
      14:      return "-";
      15:      return "*";
      default: return "/";
    endcase
  endfunction

  // One lexeme-shaped chunk of source text; adjacent chunks often run together,
  // which is what produces the two-token words.
  task automatic send_fragment();
    int    pick;
    int    pos;
    string w;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if ($urandom_range(0, 1)) begin
        w = kw_word($urandom_range(0, 10));
        case ($urandom_range(0, 3))
          0: send_text(w);
          1: send_text(w.substr(0, w.len() - 2));
          2: begin
            send_text(w);
            send_word(rand_alnum(), 1'b0);
          end
          default: begin
            pos    = $urandom_range(0, w.len() - 1);
            w[pos] = w[pos] ^ 8'h20;
            send_text(w);
          end
        endcase
      end else begin
        send_word(rand_letter(), 1'b0);
        repeat ($urandom_range(0, 7)) send_word(rand_alnum(), 1'b0);
      end
    end else if (pick < 45) begin
      send_word(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
      repeat ($urandom_range(0, 5))
        send_word($urandom_range(0, 3) == 0 ? 8'h2E : 8'(8'h30 + $urandom_range(0, 9)), 1'b0);
    end else if (pick < 65) begin
      send_text(op_text($urandom_range(0, 16)));
    end else if (pick < 85) begin
      case ($urandom_range(0, 2))
        0:       send_word(8'h20, 1'b0);
        1:       send_word(8'h0A, 1'b0);
        default: send_word(8'($urandom_range(9, 13)), 1'b0);
      endcase
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Token side: take a word when offered, then decide the next ready.
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_token(m_axis_tdata_o, m_axis_tlast_o);
      m_axis_tready_i <= ($urandom_range(0, 99) >= sink_stall);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= STALL_LIMIT) begin
      $display("pascal_subset_tokenizer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Paired operators and their broken forms, both byte extremes and case
    // sensitivity of keywords.
    send_text("do<=<>>=:=<a>9:");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("Then1.;\n");

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 74; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 74; end
        default: begin src_idle = 24; sink_stall = 24; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_fragment();
    end

    // Saturation of the lexeme length for an identifier and a number.
    src_idle   = 0;
    sink_stall = 10;
    send_word(rand_letter(), 1'b0);
    repeat (259) send_word(rand_alnum(), 1'b0);
    send_word(8'h20, 1'b0);
    repeat (260) send_word($urandom_range(0, 4) == 0 ? 8'h2E : 8'h37, 1'b0);
    send_text("x\n+\n;");

    // End marker flushing a pending keyword, ignored text, repeated end marker.
    send_text("do");
    send_word(8'($urandom_range(0, 255)), 1'b1);
    send_text("abc<");
    send_word(8'($urandom_range(0, 255)), 1'b1);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("pascal_subset_tokenizer_tb OK");
    end else begin
      $display("pascal_subset_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pst_pkg.sv
rtl/core/pst_front.sv
rtl/core/pst_queue.sv
rtl/core/pst_back.sv
rtl/core/pascal_subset_tokenizer.sv
rtl/core/pst_checker.sv
sim/pascal_subset_tokenizer_tb.sv
